[hdl/fzlf_pkg.sv]
package fzlf_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SCORE_FRAC_BITS_DEF = 16;
    localparam int Q30_BITS            = 30;
    localparam int TAYLOR_TERMS        = 16;
    localparam int RECIP_SHIFT         = 34;
    localparam int RECIP_BITS          = RECIP_SHIFT + 1;
    localparam int GAUSS_RANGE_LOG2    = 3;
    localparam int EXP_INT_BITS        = 2 * GAUSS_RANGE_LOG2 - 1;
    localparam int EXP_INT_DEPTH       = 1 << EXP_INT_BITS;
    localparam int CFG_INDEX_BITS      = 3;
    localparam longint unsigned Q30_ONE = 64'd1 << Q30_BITS;
    // exp(-1) in Q30 from the 16-term series with truncated terms
    localparam longint unsigned E1_Q30  = 64'd395007543;

    typedef enum logic [1:0] {
        MF_NONE  = 2'd0,
        MF_TRI   = 2'd1,
        MF_TRAP  = 2'd2,
        MF_GAUSS = 2'd3
    } mf_mode_t;

    typedef enum logic [2:0] {
        CLS_N  = 3'd0,
        CLS_S3 = 3'd1,
        CLS_S2 = 3'd2,
        CLS_S1 = 3'd3,
        CLS_NA = 3'd4
    } suit_class_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MF_MODE       = 3'd0,
        REG_RANGE_MIN     = 3'd1,
        REG_RANGE_MAX     = 3'd2,
        REG_PLATEAU_START = 3'd3,
        REG_SPREAD        = 3'd4,
        REG_THR_S3        = 3'd5,
        REG_THR_S2        = 3'd6,
        REG_THR_S1        = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic        fixed;
        logic        sat;
        logic        zero;
        logic        gauss;
        logic        bounded;
        suit_class_t cls;
    } tag_t;

    typedef logic [Q30_BITS:0] q30_t;
    typedef q30_t exp_tab_t [EXP_INT_DEPTH];

    function automatic exp_tab_t exp_int_table();
        exp_tab_t          tab;
        longint unsigned   acc;
        int                i;
        acc = Q30_ONE;
        for (i = 0; i < EXP_INT_DEPTH; i++) begin
            tab[i] = acc[Q30_BITS:0];
            acc    = (acc * E1_Q30) >> Q30_BITS;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_INT = exp_int_table();

endpackage

[hdl/fzlf_front.sv]
module fzlf_front #(
    parameter int SAMPLE_BITS = fzlf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [1:0]                    mf_mode,
    input  logic signed [SAMPLE_BITS-1:0] range_min,
    input  logic signed [SAMPLE_BITS-1:0] range_max,
    input  logic signed [SAMPLE_BITS-1:0] plateau_start,
    input  logic [SAMPLE_BITS-1:0]        spread,
    output logic                          out_valid,
    output logic [SAMPLE_BITS-1:0]        out_num,
    output logic [SAMPLE_BITS-1:0]        out_den,
    output fzlf_pkg::tag_t                out_tag
);

    localparam int SB = SAMPLE_BITS;
    localparam int GR = fzlf_pkg::GAUSS_RANGE_LOG2;

    logic signed [SB:0]   x_e;
    logic signed [SB:0]   min_e;
    logic signed [SB:0]   max_e;
    logic signed [SB:0]   plat_e;
    logic signed [SB:0]   d_xmin;
    logic signed [SB:0]   d_span;
    logic signed [SB:0]   d_plat;
    logic signed [SB:0]   d_peak;
    logic [SB-1:0]        sig;
    logic                 far;
    logic [SB-1:0]        num_next;
    logic [SB-1:0]        den_next;
    fzlf_pkg::tag_t       tag_next;
    logic                 valid_reg;
    logic [SB-1:0]        num_reg;
    logic [SB-1:0]        den_reg;
    fzlf_pkg::tag_t       tag_reg;

    assign x_e    = {sample[SB-1], sample};
    assign min_e  = {range_min[SB-1], range_min};
    assign max_e  = {range_max[SB-1], range_max};
    assign plat_e = {plateau_start[SB-1], plateau_start};
    assign d_xmin = x_e - min_e;
    assign d_span = max_e - min_e;
    assign d_plat = plat_e - min_e;
    assign d_peak = max_e - x_e;
    assign sig    = (spread == '0) ? SB'(1) : spread;
    assign far    = {{GR{1'b0}}, d_peak[SB-1:0]} >= {sig, {GR{1'b0}}};

    always_comb begin
        num_next         = '0;
        den_next         = SB'(1);
        tag_next.fixed   = 1'b1;
        tag_next.sat     = 1'b0;
        tag_next.zero    = 1'b0;
        tag_next.gauss   = 1'b0;
        tag_next.bounded = 1'b0;
        tag_next.cls     = fzlf_pkg::CLS_NA;
        unique case (fzlf_pkg::mf_mode_t'(mf_mode))
            fzlf_pkg::MF_TRI: begin
                if (x_e < min_e || x_e > max_e) begin
                    tag_next.cls = fzlf_pkg::CLS_N;
                end else if (max_e != min_e) begin
                    tag_next.fixed   = 1'b0;
                    tag_next.bounded = 1'b1;
                    num_next         = d_xmin[SB-1:0];
                    den_next         = d_span[SB-1:0];
                end
            end
            fzlf_pkg::MF_TRAP: begin
                if (x_e < min_e || x_e > max_e) begin
                    tag_next.cls = fzlf_pkg::CLS_N;
                end else if (x_e < plat_e) begin
                    tag_next.fixed = 1'b0;
                    num_next       = d_xmin[SB-1:0];
                    den_next       = d_plat[SB-1:0];
                end else begin
                    tag_next.sat = 1'b1;
                    tag_next.cls = fzlf_pkg::CLS_S1;
                end
            end
            fzlf_pkg::MF_GAUSS: begin
                if (x_e > max_e) begin
                    tag_next.cls = fzlf_pkg::CLS_N;
                end else begin
                    tag_next.fixed   = 1'b0;
                    tag_next.gauss   = 1'b1;
                    tag_next.bounded = 1'b1;
                    tag_next.zero    = far;
                    num_next         = d_peak[SB-1:0];
                    den_next         = sig;
                end
            end
            fzlf_pkg::MF_NONE: begin
                tag_next.cls = fzlf_pkg::CLS_NA;
            end
            default: begin
                tag_next.cls = fzlf_pkg::CLS_NA;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            den_reg <= den_next;
            tag_reg <= tag_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_tag   = tag_reg;

endmodule

[hdl/fzlf_div.sv]
module fzlf_div #(
    parameter int SAMPLE_BITS     = fzlf_pkg::SAMPLE_BITS_DEF,
    parameter int SCORE_FRAC_BITS = fzlf_pkg::SCORE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [SAMPLE_BITS-1:0]        in_num,
    input  logic [SAMPLE_BITS-1:0]        in_den,
    input  fzlf_pkg::tag_t                in_tag,
    output logic                          out_valid,
    output logic [SCORE_FRAC_BITS+fzlf_pkg::GAUSS_RANGE_LOG2-1:0] out_q,
    output fzlf_pkg::tag_t                out_tag
);

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SCORE_FRAC_BITS;
    localparam int GR = fzlf_pkg::GAUSS_RANGE_LOG2;
    localparam int QW = F + GR;

    logic                 valid_reg [QW];
    logic [SB-1:0]        rem_reg   [QW];
    logic [SB-1:0]        den_reg   [QW];
    logic [QW-1:0]        rest_reg  [QW];
    logic [QW-1:0]        q_reg     [QW];
    fzlf_pkg::tag_t       tag_reg   [QW];

    genvar i;
    for (i = 0; i < QW; i++) begin : g_step
        logic                 p_valid;
        logic [SB-1:0]        p_rem;
        logic [SB-1:0]        p_den;
        logic [QW-1:0]        p_rest;
        logic [QW-1:0]        p_q;
        fzlf_pkg::tag_t       p_tag;
        logic [SB:0]          shifted;
        logic                 ge;
        logic [SB:0]          diff;

        if (i == 0) begin : g_first
            assign p_valid = in_valid;
            assign p_rem   = in_num >> GR;
            assign p_den   = in_den;
            assign p_rest  = {in_num[GR-1:0], {F{1'b0}}};
            assign p_q     = '0;
            assign p_tag   = in_tag;
        end else begin : g_next
            assign p_valid = valid_reg[i-1];
            assign p_rem   = rem_reg[i-1];
            assign p_den   = den_reg[i-1];
            assign p_rest  = rest_reg[i-1];
            assign p_q     = q_reg[i-1];
            assign p_tag   = tag_reg[i-1];
        end

        assign shifted = {p_rem, p_rest[QW-1]};
        assign ge      = shifted >= {1'b0, p_den};
        assign diff    = shifted - {1'b0, p_den};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= p_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? diff[SB-1:0] : shifted[SB-1:0];
                den_reg[i]  <= p_den;
                rest_reg[i] <= {p_rest[QW-2:0], 1'b0};
                q_reg[i]    <= {p_q[QW-2:0], ge};
                tag_reg[i]  <= p_tag;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

[hdl/fzlf_exp.sv]
module fzlf_exp #(
    parameter int SCORE_FRAC_BITS = fzlf_pkg::SCORE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [SCORE_FRAC_BITS+fzlf_pkg::GAUSS_RANGE_LOG2-1:0] in_q,
    input  fzlf_pkg::tag_t                in_tag,
    output logic                          out_valid,
    output logic [SCORE_FRAC_BITS+fzlf_pkg::GAUSS_RANGE_LOG2-1:0] out_q,
    output fzlf_pkg::tag_t                out_tag,
    output logic [SCORE_FRAC_BITS:0]      out_score
);

    localparam int F   = SCORE_FRAC_BITS;
    localparam int QW  = F + fzlf_pkg::GAUSS_RANGE_LOG2;
    localparam int SQW = 2 * QW;
    localparam int NB  = fzlf_pkg::EXP_INT_BITS;
    localparam int T   = fzlf_pkg::TAYLOR_TERMS;
    localparam int QB  = fzlf_pkg::Q30_BITS;
    localparam int FP  = QB - F;
    localparam int RS  = fzlf_pkg::RECIP_SHIFT;
    localparam int RB  = fzlf_pkg::RECIP_BITS;
    localparam logic [QB:0]  Q30_ONE_V = {1'b1, {QB{1'b0}}};
    localparam logic [F:0]   ONE       = {1'b1, {F{1'b0}}};
    localparam logic [QB+3:0] RND      = (QB + 4)'(1) << (FP - 1);

    logic                 v0_reg;
    logic [QW-1:0]        q0_reg;
    fzlf_pkg::tag_t       tag0_reg;
    logic [SQW-1:0]       sq0_reg;

    logic                 v1_reg;
    logic [QW-1:0]        q1_reg;
    fzlf_pkg::tag_t       tag1_reg;
    logic [NB-1:0]        n1_reg;
    logic [QB-1:0]        f1_reg;

    logic                 mv_reg    [T];
    logic [QW-1:0]        mq_reg    [T];
    fzlf_pkg::tag_t       mtag_reg  [T];
    logic [NB-1:0]        mn_reg    [T];
    logic [QB-1:0]        mf_reg    [T];
    logic [QB-1:0]        mprod_reg [T];
    logic [QB+1:0]        mpos_reg  [T];
    logic [QB+1:0]        mneg_reg  [T];

    logic                 dv_reg    [T];
    logic [QW-1:0]        dq_reg    [T];
    fzlf_pkg::tag_t       dtag_reg  [T];
    logic [NB-1:0]        dn_reg    [T];
    logic [QB-1:0]        df_reg    [T];
    logic [QB:0]          dterm_reg [T];
    logic [QB+1:0]        dpos_reg  [T];
    logic [QB+1:0]        dneg_reg  [T];

    logic                 v2_reg;
    logic [QW-1:0]        q2_reg;
    fzlf_pkg::tag_t       tag2_reg;
    logic [QB+1:0]        ef2_reg;
    logic [QB:0]          en2_reg;

    logic                 v3_reg;
    logic [QW-1:0]        q3_reg;
    fzlf_pkg::tag_t       tag3_reg;
    logic [QB+2:0]        val3_reg;

    logic                 v4_reg;
    logic [QW-1:0]        q4_reg;
    fzlf_pkg::tag_t       tag4_reg;
    logic [F:0]           score4_reg;

    logic [2*QB+2:0]      ev_prod;
    logic [QB+3:0]        rsum;
    logic [F+3:0]         rshift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= dv_reg[T-1];
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q0_reg   <= in_q;
            tag0_reg <= in_tag;
            sq0_reg  <= SQW'(in_q) * SQW'(in_q);

            q1_reg   <= q0_reg;
            tag1_reg <= tag0_reg;
            n1_reg   <= sq0_reg[SQW-1:2*F+1];
            f1_reg   <= {sq0_reg[2*F:F+1], {FP{1'b0}}};
        end
    end

    genvar k;
    for (k = 0; k < T; k++) begin : g_term
        localparam int K = k + 1;
        localparam logic [RB-1:0] RECIP =
            RB'(((64'd1 << RS) + 64'(K) - 64'd1) / 64'(K));

        logic                 p_valid;
        logic [QW-1:0]        p_q;
        fzlf_pkg::tag_t       p_tag;
        logic [NB-1:0]        p_n;
        logic [QB-1:0]        p_f;
        logic [QB:0]          p_term;
        logic [QB+1:0]        p_pos;
        logic [QB+1:0]        p_neg;
        logic [2*QB:0]        mul;
        logic [RB+QB-1:0]     rmul;
        logic [QB:0]          nterm;

        if (k == 0) begin : g_first
            assign p_valid = v1_reg;
            assign p_q     = q1_reg;
            assign p_tag   = tag1_reg;
            assign p_n     = n1_reg;
            assign p_f     = f1_reg;
            assign p_term  = Q30_ONE_V;
            assign p_pos   = (QB + 2)'(Q30_ONE_V);
            assign p_neg   = '0;
        end else begin : g_next
            assign p_valid = dv_reg[k-1];
            assign p_q     = dq_reg[k-1];
            assign p_tag   = dtag_reg[k-1];
            assign p_n     = dn_reg[k-1];
            assign p_f     = df_reg[k-1];
            assign p_term  = dterm_reg[k-1];
            assign p_pos   = dpos_reg[k-1];
            assign p_neg   = dneg_reg[k-1];
        end

        assign mul   = (2 * QB + 1)'(p_term) * (2 * QB + 1)'(p_f);
        assign rmul  = (RB + QB)'(mprod_reg[k]) * (RB + QB)'(RECIP);
        assign nterm = rmul[RS+QB:RS];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mv_reg[k] <= 1'b0;
                dv_reg[k] <= 1'b0;
            end else if (en) begin
                mv_reg[k] <= p_valid;
                dv_reg[k] <= mv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                mq_reg[k]    <= p_q;
                mtag_reg[k]  <= p_tag;
                mn_reg[k]    <= p_n;
                mf_reg[k]    <= p_f;
                mprod_reg[k] <= mul[2*QB-1:QB];
                mpos_reg[k]  <= p_pos;
                mneg_reg[k]  <= p_neg;

                dq_reg[k]    <= mq_reg[k];
                dtag_reg[k]  <= mtag_reg[k];
                dn_reg[k]    <= mn_reg[k];
                df_reg[k]    <= mf_reg[k];
                dterm_reg[k] <= nterm;
                if ((K % 2) == 1) begin
                    dpos_reg[k] <= mpos_reg[k];
                    dneg_reg[k] <= mneg_reg[k] + (QB + 2)'(nterm);
                end else begin
                    dpos_reg[k] <= mpos_reg[k] + (QB + 2)'(nterm);
                    dneg_reg[k] <= mneg_reg[k];
                end
            end
        end
    end

    assign ev_prod = (2 * QB + 3)'(en2_reg) * (2 * QB + 3)'(ef2_reg);
    assign rsum    = (QB + 4)'(val3_reg) + RND;
    assign rshift  = rsum[QB+3:FP];

    always_ff @(posedge aclk) begin
        if (en) begin
            q2_reg   <= dq_reg[T-1];
            tag2_reg <= dtag_reg[T-1];
            ef2_reg  <= (dpos_reg[T-1] > dneg_reg[T-1]) ?
                        dpos_reg[T-1] - dneg_reg[T-1] : '0;
            en2_reg  <= fzlf_pkg::EXP_INT[dn_reg[T-1]];

            q3_reg   <= q2_reg;
            tag3_reg <= tag2_reg;
            val3_reg <= ev_prod[2*QB+2:QB];

            q4_reg     <= q3_reg;
            tag4_reg   <= tag3_reg;
            score4_reg <= (rshift > (F + 4)'(ONE)) ? ONE : rshift[F:0];
        end
    end

    assign out_valid = v4_reg;
    assign out_q     = q4_reg;
    assign out_tag   = tag4_reg;
    assign out_score = score4_reg;

endmodule

[hdl/fzlf_class.sv]
module fzlf_class #(
    parameter int SCORE_FRAC_BITS = fzlf_pkg::SCORE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [SCORE_FRAC_BITS+fzlf_pkg::GAUSS_RANGE_LOG2-1:0] in_q,
    input  fzlf_pkg::tag_t                in_tag,
    input  logic [SCORE_FRAC_BITS:0]      in_score,
    input  logic [SCORE_FRAC_BITS:0]      thr_s3,
    input  logic [SCORE_FRAC_BITS:0]      thr_s2,
    input  logic [SCORE_FRAC_BITS:0]      thr_s1,
    output logic                          out_valid,
    output logic [SCORE_FRAC_BITS:0]      out_membership,
    output logic [2:0]                    out_suit_class
);

    localparam int F = SCORE_FRAC_BITS;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [F:0]              score;
    fzlf_pkg::suit_class_t   cls;
    logic                    valid_reg;
    logic [F:0]              membership_reg;
    fzlf_pkg::suit_class_t   cls_reg;

    always_comb begin
        if (in_tag.fixed) begin
            score = in_tag.sat ? ONE : '0;
            cls   = in_tag.cls;
        end else begin
            if (in_tag.zero) begin
                score = '0;
            end else if (in_tag.gauss) begin
                score = in_score;
            end else begin
                score = in_q[F:0];
            end
            if (score < thr_s3) begin
                cls = fzlf_pkg::CLS_N;
            end else if (score < thr_s2) begin
                cls = fzlf_pkg::CLS_S3;
            end else if (score < thr_s1) begin
                cls = fzlf_pkg::CLS_S2;
            end else if (!in_tag.bounded || score <= ONE) begin
                cls = fzlf_pkg::CLS_S1;
            end else begin
                cls = fzlf_pkg::CLS_NA;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            membership_reg <= score;
            cls_reg        <= cls;
        end
    end

    assign out_valid      = valid_reg;
    assign out_membership = membership_reg;
    assign out_suit_class = cls_reg;

endmodule

[hdl/fuzzy_left_face_membership_classifier_core.sv]
// Scores each signed sample against the rising face of a triangular,
// trapezoidal or Gaussian membership function and sorts the score into
// N, S3, S2, S1 or NA by three thresholds. One transaction is accepted per
// cycle while the pipe is not stalled, and each passes through the range
// checks, one restoring-divider stage per quotient bit (SCORE_FRAC_BITS + 3),
// then squaring, two stages per term of the 16-term exp series, the
// integer-power lookup, the final product, rounding and the classifying
// output register. All stages advance together whenever the output
// register is empty or being taken.
module fuzzy_left_face_membership_classifier_core #(
    parameter int SAMPLE_BITS     = fzlf_pkg::SAMPLE_BITS_DEF,
    parameter int SCORE_FRAC_BITS = fzlf_pkg::SCORE_FRAC_BITS_DEF,
    parameter int CFG_DATA_BITS   = (SAMPLE_BITS > SCORE_FRAC_BITS + 1) ?
                                    SAMPLE_BITS : SCORE_FRAC_BITS + 1
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [SAMPLE_BITS-1:0]          s_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [SCORE_FRAC_BITS:0]               m_membership,
    output logic [2:0]                             m_suit_class,
    input  logic                                   cfg_wen,
    input  logic [fzlf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]               cfg_wdata
);

    localparam int SB = SAMPLE_BITS;
    localparam int F  = SCORE_FRAC_BITS;
    localparam int QW = F + fzlf_pkg::GAUSS_RANGE_LOG2;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [1:0]            mf_mode_reg;
    logic signed [SB-1:0]  range_min_reg;
    logic signed [SB-1:0]  range_max_reg;
    logic signed [SB-1:0]  plateau_start_reg;
    logic [SB-1:0]         spread_reg;
    logic [F:0]            thr_s3_reg;
    logic [F:0]            thr_s2_reg;
    logic [F:0]            thr_s1_reg;

    logic                  en;
    logic                  fr_valid;
    logic [SB-1:0]         fr_num;
    logic [SB-1:0]         fr_den;
    fzlf_pkg::tag_t        fr_tag;
    logic                  dv_valid;
    logic [QW-1:0]         dv_q;
    fzlf_pkg::tag_t        dv_tag;
    logic                  ex_valid;
    logic [QW-1:0]         ex_q;
    fzlf_pkg::tag_t        ex_tag;
    logic [F:0]            ex_score;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mf_mode_reg       <= fzlf_pkg::MF_TRI;
            range_min_reg     <= '0;
            range_max_reg     <= {1'b0, {(SB - 1){1'b1}}};
            plateau_start_reg <= SB'(1) << (SB - 2);
            spread_reg        <= SB'(1) << (SB - 4);
            thr_s3_reg        <= ONE >> 2;
            thr_s2_reg        <= ONE >> 1;
            thr_s1_reg        <= (ONE >> 1) + (ONE >> 2);
        end else if (cfg_wen) begin
            unique case (fzlf_pkg::reg_index_t'(cfg_index))
                fzlf_pkg::REG_MF_MODE:       mf_mode_reg       <= cfg_wdata[1:0];
                fzlf_pkg::REG_RANGE_MIN:     range_min_reg     <= cfg_wdata[SB-1:0];
                fzlf_pkg::REG_RANGE_MAX:     range_max_reg     <= cfg_wdata[SB-1:0];
                fzlf_pkg::REG_PLATEAU_START: plateau_start_reg <= cfg_wdata[SB-1:0];
                fzlf_pkg::REG_SPREAD:        spread_reg        <= cfg_wdata[SB-1:0];
                fzlf_pkg::REG_THR_S3:        thr_s3_reg        <= cfg_wdata[F:0];
                fzlf_pkg::REG_THR_S2:        thr_s2_reg        <= cfg_wdata[F:0];
                fzlf_pkg::REG_THR_S1:        thr_s1_reg        <= cfg_wdata[F:0];
                default: ;
            endcase
        end
    end

    // advance the whole pipe when the output register is free
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    fzlf_front #(
        .SAMPLE_BITS (SB)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .sample        (s_sample),
        .mf_mode       (mf_mode_reg),
        .range_min     (range_min_reg),
        .range_max     (range_max_reg),
        .plateau_start (plateau_start_reg),
        .spread        (spread_reg),
        .out_valid     (fr_valid),
        .out_num       (fr_num),
        .out_den       (fr_den),
        .out_tag       (fr_tag)
    );

    fzlf_div #(
        .SAMPLE_BITS     (SB),
        .SCORE_FRAC_BITS (F)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .in_tag    (fr_tag),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_tag   (dv_tag)
    );

    fzlf_exp #(
        .SCORE_FRAC_BITS (F)
    ) u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .in_q      (dv_q),
        .in_tag    (dv_tag),
        .out_valid (ex_valid),
        .out_q     (ex_q),
        .out_tag   (ex_tag),
        .out_score (ex_score)
    );

    fzlf_class #(
        .SCORE_FRAC_BITS (F)
    ) u_class (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (ex_valid),
        .in_q           (ex_q),
        .in_tag         (ex_tag),
        .in_score       (ex_score),
        .thr_s3         (thr_s3_reg),
        .thr_s2         (thr_s2_reg),
        .thr_s1         (thr_s1_reg),
        .out_valid      (m_valid),
        .out_membership (m_membership),
        .out_suit_class (m_suit_class)
    );

    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_membership <= ONE)
        else $error("membership above one");

    a_class_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_suit_class <= fzlf_pkg::CLS_NA)
        else $error("class code out of range");

    a_na_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_suit_class == fzlf_pkg::CLS_NA) |-> m_membership == '0)
        else $error("NA class with nonzero membership");

endmodule

[tb/fuzzy_left_face_membership_classifier_core_tb.sv]
module fuzzy_left_face_membership_classifier_core_tb;
    import fzlf_pkg::*;

    localparam int      DRAIN_CYCLES = 80;
    localparam longint unsigned Q30V = 64'd1 << 30;
    localparam longint unsigned ONE_SCORE = 64'd1 << 16;

    typedef struct {
        logic [16:0] membership;
        suit_class_t suit_class;
    } score_exp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [16:0] m_membership;
    logic [2:0] m_suit_class;
    logic cfg_wen = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [16:0] cfg_wdata = '0;

    mf_mode_t           cur_mode;
    logic signed [15:0] cur_rmin;
    logic signed [15:0] cur_rmax;
    logic signed [15:0] cur_plateau;
    logic [15:0]        cur_spread;
    logic [16:0]        cur_thr_s3;
    logic [16:0]        cur_thr_s2;
    logic [16:0]        cur_thr_s1;

    score_exp_t score_q[$];
    int         err_cnt = 0;
    bit         calm = 1'b0;

    fuzzy_left_face_membership_classifier_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_membership(m_membership), .m_suit_class(m_suit_class),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("fuzzy_left_face_membership_classifier_core test failed");
        $finish;
    end

    function automatic longint unsigned exp_neg_fixed(input longint unsigned f);
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned term;
        pos  = Q30V;
        neg  = 0;
        term = Q30V;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * f) >> 30) / longint'(k);
            if (k % 2 == 1) neg += term;
            else pos += term;
        end
        return (pos > neg) ? pos - neg : 0;
    endfunction

    function automatic longint unsigned gauss_membership(input longint unsigned d,
                                                         input longint unsigned sig);
        longint unsigned q, t, n, f, en, e1, val;
        if (sig == 0) sig = 1;
        if (d >= 8 * sig) return 0;
        q  = (d << 16) / sig;
        t  = (q * q) >> 17;
        n  = t >> 16;
        f  = (t & (ONE_SCORE - 1)) << 14;
        e1 = exp_neg_fixed(Q30V);
        en = Q30V;
        for (longint unsigned i = 0; i < n; i++) en = (en * e1) >> 30;
        val = (en * exp_neg_fixed(f)) >> 30;
        val = (val + (64'd1 << 13)) >> 14;
        return (val > ONE_SCORE) ? ONE_SCORE : val;
    endfunction

    function automatic suit_class_t grade(input longint unsigned s, input bit bounded);
        if (s < cur_thr_s3) return CLS_N;
        if (s < cur_thr_s2) return CLS_S3;
        if (s < cur_thr_s1) return CLS_S2;
        if (!bounded || s <= ONE_SCORE) return CLS_S1;
        return CLS_NA;
    endfunction

    function automatic score_exp_t predict_score(input logic signed [15:0] smp);
        score_exp_t      r;
        longint          x, lo, hi, pl;
        longint unsigned s;
        x  = smp;
        lo = cur_rmin;
        hi = cur_rmax;
        pl = cur_plateau;
        s  = 0;
        r.suit_class = CLS_NA;
        case (cur_mode)
            MF_TRI: begin
                if (x < lo || x > hi) r.suit_class = CLS_N;
                else if (hi != lo) begin
                    s = (longint'(x - lo) << 16) / longint'(hi - lo);
                    r.suit_class = grade(s, 1'b1);
                end
            end
            MF_TRAP: begin
                if (x < lo || x > hi) r.suit_class = CLS_N;
                else if (x < pl) begin
                    s = (longint'(x - lo) << 16) / longint'(pl - lo);
                    r.suit_class = grade(s, 1'b0);
                end else begin
                    s = ONE_SCORE;
                    r.suit_class = CLS_S1;
                end
            end
            MF_GAUSS: begin
                if (x > hi) r.suit_class = CLS_N;
                else begin
                    s = gauss_membership(longint'(hi - x), longint'(cur_spread));
                    r.suit_class = grade(s, 1'b1);
                end
            end
            default: r.suit_class = CLS_NA;
        endcase
        r.membership = s[16:0];
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        err_cnt++;
    endtask

    task automatic send_sample(input logic signed [15:0] smp);
        int g;
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        score_q.push_back(predict_score(smp));
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (score_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [16:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        case (idx)
            REG_MF_MODE:       cur_mode    = mf_mode_t'(val[1:0]);
            REG_RANGE_MIN:     cur_rmin    = val[15:0];
            REG_RANGE_MAX:     cur_rmax    = val[15:0];
            REG_PLATEAU_START: cur_plateau = val[15:0];
            REG_SPREAD:        cur_spread  = val[15:0];
            REG_THR_S3:        cur_thr_s3  = val;
            REG_THR_S2:        cur_thr_s2  = val;
            default:           cur_thr_s1  = val;
        endcase
    endtask

    task automatic set_all(input mf_mode_t md, input logic signed [15:0] lo,
                           input logic signed [15:0] hi, input logic signed [15:0] pl,
                           input logic [15:0] sp, input logic [16:0] t3,
                           input logic [16:0] t2, input logic [16:0] t1);
        wait_idle();
        write_reg(REG_MF_MODE, {15'd0, md});
        write_reg(REG_RANGE_MIN, {1'b0, lo});
        write_reg(REG_RANGE_MAX, {1'b0, hi});
        write_reg(REG_PLATEAU_START, {1'b0, pl});
        write_reg(REG_SPREAD, {1'b0, sp});
        write_reg(REG_THR_S3, t3);
        write_reg(REG_THR_S2, t2);
        write_reg(REG_THR_S1, t1);
    endtask

    always @(posedge aclk) begin
        score_exp_t e;
        if (aresetn && m_valid && m_ready) begin
            if (score_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_membership, -1);
            end else begin
                e = score_q.pop_front();
                if (m_membership !== e.membership)
                    report_mismatch("membership", m_membership, e.membership);
                if (m_suit_class !== e.suit_class)
                    report_mismatch("suit_class", m_suit_class, e.suit_class);
            end
        end
    end

    initial begin
        int r;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat (1 + $urandom_range(0, 6)) @(posedge aclk);
            r = calm ? 0 : gap_len();
            if (r > 0) begin
                m_ready <= 1'b0;
                repeat (r) @(posedge aclk);
            end
        end
    end

    task automatic test_reset_defaults();
        cur_mode = MF_TRI; cur_rmin = 0; cur_rmax = 32767; cur_plateau = 16384;
        cur_spread = 4096; cur_thr_s3 = 16384; cur_thr_s2 = 32768; cur_thr_s1 = 49152;
        send_sample(16'sh8000);
        send_sample(0);
        send_sample(16384);
        send_sample(32767);
    endtask

    task automatic test_triangular();
        set_all(MF_TRI, -32768, 32767, 0, 1, 0, 65536, 65536);
        send_sample(-32768);
        send_sample(-1);
        send_sample(32767);
        set_all(MF_TRI, 5, 5, 0, 1, 16384, 32768, 49152);
        send_sample(5);
        send_sample(4);
        set_all(MF_TRI, 100, -100, 0, 1, 16384, 32768, 49152);
        send_sample(0);
    endtask

    task automatic test_trapezoidal();
        set_all(MF_TRAP, -1000, 1000, 0, 1, 1, 2, 65536);
        send_sample(-1000);
        send_sample(-1);
        send_sample(0);
        send_sample(1000);
        send_sample(1001);
    endtask

    task automatic test_gaussian();
        set_all(MF_GAUSS, 0, 100, 0, 0, 16384, 32768, 49152);
        send_sample(100);
        send_sample(99);
        send_sample(101);
        set_all(MF_GAUSS, -32768, 32767, 0, 16'hffff, 0, 0, 0);
        send_sample(16'sh8000);
        send_sample(0);
        set_all(MF_GAUSS, 0, 32767, 0, 4096, 16384, 32768, 49152);
        send_sample(32767 - 3 * 4096);
        send_sample(32767 - 8 * 4096);
    endtask

    task automatic test_unused_mode();
        set_all(MF_NONE, 0, 32767, 16384, 4096, 16384, 32768, 49152);
        send_sample(1234);
    endtask

    task automatic test_random();
        logic signed [15:0] lo, hi, pl, smp;
        logic [16:0] t[3];
        logic [16:0] tmp;
        mf_mode_t    md;
        int          span;
        for (int ph = 0; ph < 14; ph++) begin
            md = mf_mode_t'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3));
            lo = $urandom;
            hi = $urandom;
            if ($urandom_range(0, 9) != 0 && lo > hi) begin
                tmp = lo; lo = hi; hi = tmp[15:0];
            end
            span = int'(hi) - int'(lo);
            pl = (span > 0) ? 16'(int'(lo) + $urandom_range(1, span)) : 16'($urandom);
            for (int i = 0; i < 3; i++) t[i] = $urandom_range(0, 65536);
            if (t[0] > t[1]) begin tmp = t[0]; t[0] = t[1]; t[1] = tmp; end
            if (t[1] > t[2]) begin tmp = t[1]; t[1] = t[2]; t[2] = tmp; end
            if (t[0] > t[1]) begin tmp = t[0]; t[0] = t[1]; t[1] = tmp; end
            set_all(md, lo, hi, pl, 16'($urandom_range(0, 9) == 0 ? $urandom :
                    $urandom_range(0, 3000)), t[0], t[1], t[2]);
            calm = (ph % 4 == 3);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 4) == 0 || span <= 0) smp = $urandom;
                else if (md == MF_GAUSS)
                    smp = 16'(int'(hi) - $urandom_range(0, 8 * int'(cur_spread) + 2));
                else smp = 16'(int'(lo) + $urandom_range(0, span));
                send_sample(smp);
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_triangular();
        test_trapezoidal();
        test_gaussian();
        test_unused_mode();
        test_random();
        wait_idle();
        if (err_cnt == 0) begin
            $display("fuzzy_left_face_membership_classifier_core test passed");
        end else begin
            $display("fuzzy_left_face_membership_classifier_core test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/fzlf_pkg.sv
hdl/fzlf_front.sv
hdl/fzlf_div.sv
hdl/fzlf_exp.sv
hdl/fzlf_class.sv
hdl/fuzzy_left_face_membership_classifier_core.sv
tb/fuzzy_left_face_membership_classifier_core_tb.sv
